// ----- design/ttc_pkg.sv -----
// Shared types, widths and constants for the tilt-compensated compass heading.
// Holds the CORDIC arctangent table and the hard-iron offset function.
// No dependencies.
`default_nettype none

package ttc_pkg;

  // Angle units and fraction setting
  localparam int ANGLE_FRAC_BITS_DEF = 6;
  localparam int ANG_UNIT_BITS       = 20;

  // Iteration counts
  localparam int STEPS_PER_STAGE = 2;
  localparam int SQRT_STEPS      = 24;
  localparam int CORDIC_STEPS    = 24;

  // Datapath widths
  localparam int RAD_W    = 48;   // |a|^2 << 16
  localparam int ROOT_W   = 24;   // floor sqrt of the above
  localparam int REM_W    = 27;   // sqrt partial remainder
  localparam int PROD_W   = 59;   // E.x * r and N.x * 256
  localparam int MAG_W    = 58;   // magnitudes of the above
  localparam int PRE_W    = 30;   // CORDIC entry width
  localparam int SHAMT_W  = 6;
  localparam int CRD_W    = 34;
  localparam int ANG_W    = 29;
  localparam int HEAD_W   = 15;

  typedef logic signed [15:0]       s16_t;
  typedef logic signed [16:0]       mag_t;
  typedef logic signed [33:0]       ecomp_t;
  typedef logic signed [50:0]       ncomp_t;
  typedef logic [ROOT_W-1:0]        root_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [CRD_W-1:0]  crd_t;
  typedef logic signed [ANG_W-1:0]  ang_t;

  // Side data carried alongside the square root
  typedef struct packed {
    logic   degen;
    ecomp_t ex;
    ncomp_t nx;
  } side_t;

  // Quadrant and degenerate flags carried alongside the CORDIC
  typedef struct packed {
    logic xneg;
    logic yneg;
    logic degen;
  } quad_t;

  // One result word
  typedef struct packed {
    logic [HEAD_W-1:0] heading;
    logic              degen;
  } res_t;

  // Register map
  typedef enum logic [2:0] {
    CFG_MIN_X = 3'd0,
    CFG_MAX_X = 3'd1,
    CFG_MIN_Y = 3'd2,
    CFG_MAX_Y = 3'd3,
    CFG_MIN_Z = 3'd4,
    CFG_MAX_Z = 3'd5
  } cfg_reg_t;

  localparam s16_t RST_MIN_X = -16'sd711;
  localparam s16_t RST_MAX_X = 16'sd591;
  localparam s16_t RST_MIN_Y = -16'sd1650;
  localparam s16_t RST_MAX_Y = -16'sd406;
  localparam s16_t RST_MIN_Z = -16'sd3399;
  localparam s16_t RST_MAX_Z = -16'sd2146;

  // Fixed angles in units of 2^-20 degree
  localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(90 << ANG_UNIT_BITS);
  localparam logic [ANG_W-1:0] ANG_180 = ANG_W'(180 << ANG_UNIT_BITS);
  localparam logic [ANG_W-1:0] ANG_360 = ANG_W'(360 << ANG_UNIT_BITS);

  // atan(2^-i) in units of 2^-20 degree
  localparam ang_t ATAN_TAB [CORDIC_STEPS] = '{
    29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121,
    29'sd3750058,  29'sd1876857,  29'sd938658,   29'sd469357,
    29'sd234682,   29'sd117342,   29'sd58671,    29'sd29335,
    29'sd14668,    29'sd7334,     29'sd3667,     29'sd1833,
    29'sd917,      29'sd458,      29'sd229,      29'sd115,
    29'sd57,       29'sd29,       29'sd14,       29'sd7
  };

  // Hard-iron offset: (lo + hi) / 2, truncated toward zero
  function automatic s16_t hard_iron_off(input s16_t lo, input s16_t hi);
    logic signed [16:0] sum;
    logic signed [16:0] adj;
    sum = 17'(lo) + 17'(hi);
    adj = sum + $signed({16'd0, sum[16]});
    return adj[16:1];
  endfunction

endpackage

`default_nettype wire

// ----- design/tilt_compensated_compass_heading.sv -----
// Top level of the tilt-compensated compass heading pipeline.
// Uses ttc_pkg, ttc_front, ttc_isqrt, ttc_prescale and ttc_cordic.
//
//   channel  direction  handshake             payload
//   in_      sink       in_valid / in_ready   accel_x/y/z, field_x/y/z (s16)
//   out_     source     out_valid / out_ready heading (u15), degenerate
//   cfg_     sink       cfg_we                cfg_index (3b), cfg_wdata (16b)
//
// One word is accepted per cycle while the output buffer is not full; the
// pipeline includes the 12-stage square root and 12-stage CORDIC.
// A two-word output buffer sits after the last stage; the whole pipeline
// holds only when that buffer is full, so a single waiting result does not
// block input. Synchronous active-low reset clears valid bits and buffer fill
// and loads the calibration registers with their reset values; no clearing pass is needed.
`default_nettype none

module tilt_compensated_compass_heading import ttc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_field_x,
  input  logic signed [15:0] in_field_y,
  input  logic signed [15:0] in_field_z,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [14:0]       out_heading,
  output logic              out_degenerate,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);

  localparam int RND_SHIFT = ANG_UNIT_BITS - ANGLE_FRAC_BITS;
  localparam logic [ANG_W:0] ROUND_HALF = (ANG_W+1)'(1) << (RND_SHIFT - 1);
  localparam int HEAD_MAX = 360 << ANGLE_FRAC_BITS;

  // calibration registers
  s16_t min_x_r, max_x_r, min_y_r, max_y_r, min_z_r, max_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= RST_MIN_X;
      max_x_r <= RST_MAX_X;
      min_y_r <= RST_MIN_Y;
      max_y_r <= RST_MAX_Y;
      min_z_r <= RST_MIN_Z;
      max_z_r <= RST_MAX_Z;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_X: min_x_r <= cfg_wdata;
        CFG_MAX_X: max_x_r <= cfg_wdata;
        CFG_MIN_Y: min_y_r <= cfg_wdata;
        CFG_MAX_Y: max_y_r <= cfg_wdata;
        CFG_MIN_Z: min_z_r <= cfg_wdata;
        CFG_MAX_Z: max_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  s16_t off_x, off_y, off_z;
  assign off_x = hard_iron_off(min_x_r, max_x_r);
  assign off_y = hard_iron_off(min_y_r, max_y_r);
  assign off_z = hard_iron_off(min_z_r, max_z_r);

  // pipeline advance: held only when the output buffer is full
  logic [1:0] cnt_r;
  logic       en;
  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  logic        fr_vld;
  logic [31:0] fr_asq;
  side_t       fr_side;

  ttc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .accel_x  (in_accel_x),
    .accel_y  (in_accel_y),
    .accel_z  (in_accel_z),
    .field_x  (in_field_x),
    .field_y  (in_field_y),
    .field_z  (in_field_z),
    .off_x    (off_x),
    .off_y    (off_y),
    .off_z    (off_z),
    .out_vld  (fr_vld),
    .asq_out  (fr_asq),
    .side_out (fr_side)
  );

  logic  sq_vld;
  root_t sq_root;
  side_t sq_side;

  ttc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .asq_in   (fr_asq),
    .side_in  (fr_side),
    .out_vld  (sq_vld),
    .root_out (sq_root),
    .side_out (sq_side)
  );

  logic             ps_vld;
  logic [PRE_W-1:0] ps_x, ps_y;
  quad_t            ps_q;

  ttc_prescale u_prescale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sq_vld),
    .root_in  (sq_root),
    .side_in  (sq_side),
    .out_vld  (ps_vld),
    .xp_out   (ps_x),
    .yp_out   (ps_y),
    .quad_out (ps_q)
  );

  logic  cr_vld;
  ang_t  cr_z;
  quad_t cr_q;

  ttc_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (ps_vld),
    .xp_in    (ps_x),
    .yp_in    (ps_y),
    .quad_in  (ps_q),
    .out_vld  (cr_vld),
    .z_out    (cr_z),
    .quad_out (cr_q)
  );

  // clamp to 0..90 degrees and place in the right quadrant
  logic [ANG_W-1:0] phi;
  logic [ANG_W-1:0] hd_nxt;
  assign phi = cr_z[ANG_W-1] ? '0 :
               (cr_z > $signed(ANG_90)) ? ANG_90 : ANG_W'(cr_z);

  always_comb begin
    case ({cr_q.yneg, cr_q.xneg})
      2'b00:   hd_nxt = ANG_360 - phi;
      2'b01:   hd_nxt = ANG_180 + phi;
      2'b10:   hd_nxt = phi;
      2'b11:   hd_nxt = ANG_180 - phi;
      default: hd_nxt = phi;
    endcase
  end

  logic             t1_vld_r;
  logic [ANG_W-1:0] hd_r;
  logic             dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
    end else if (en) begin
      t1_vld_r <= cr_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hd_r <= hd_nxt;
      dg_r <= cr_q.degen;
    end
  end

  // round to the output fraction
  logic [ANG_W:0] hsum;
  logic [ANG_W:0] hshift;
  res_t           res_w;
  assign hsum          = {1'b0, hd_r} + ROUND_HALF;
  assign hshift        = hsum >> RND_SHIFT;
  assign res_w.heading = dg_r ? '0 : hshift[HEAD_W-1:0];
  assign res_w.degen   = dg_r;

  // two-word output buffer
  res_t head_r, tail_r;
  logic push, pop;
  assign push = en && t1_vld_r;
  assign pop  = (cnt_r != 2'd0) && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) head_r <= res_w;
        else               tail_r <= res_w;
      end
      2'b01: head_r <= tail_r;
      2'b11: begin
        if (cnt_r == 2'd1) head_r <= res_w;
        else begin
          head_r <= tail_r;
          tail_r <= res_w;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = (cnt_r != 2'd0);
  assign out_heading    = head_r.heading;
  assign out_degenerate = head_r.degen;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer fill out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input held while output buffer not full");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_heading == '0))
    else $error("degenerate result with nonzero heading");

  a_head_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((ANGLE_FRAC_BITS > 6) || (32'(out_heading) <= HEAD_MAX)))
    else $error("heading beyond 360 degrees");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("waiting result lost");
`endif

endmodule

`default_nettype wire

// ----- design/ttc_front.sv -----
// Front end: offset removal, east vector E = m x a, N.x = (a x E).x and |a|^2.
// Five register stages. Depends on ttc_pkg.
`default_nettype none

module ttc_front import ttc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_vld,
  input  s16_t         accel_x,
  input  s16_t         accel_y,
  input  s16_t         accel_z,
  input  s16_t         field_x,
  input  s16_t         field_y,
  input  s16_t         field_z,
  input  s16_t         off_x,
  input  s16_t         off_y,
  input  s16_t         off_z,
  output logic         out_vld,
  output logic [31:0]  asq_out,
  output side_t        side_out
);

  logic [4:0] vld_r;

  // stage 1
  s16_t  ax1_r, ay1_r, az1_r;
  mag_t  mx1_r, my1_r, mz1_r;
  logic signed [31:0] sqx1_r, sqy1_r, sqz1_r;
  // stage 2
  s16_t  ay2_r, az2_r;
  logic signed [32:0] myaz_r, mzay_r, mzax_r, mxaz_r, mxay_r, myax_r;
  logic [31:0] asq2_r;
  // stage 3
  s16_t   ay3_r, az3_r;
  ecomp_t ex3_r, ey3_r, ez3_r;
  logic [31:0] asq3_r;
  // stage 4
  logic signed [49:0] pn1_r, pn2_r;
  ecomp_t ex4_r;
  logic   degen4_r;
  logic [31:0] asq4_r;
  // stage 5
  side_t  side5_r;
  logic [31:0] asq5_r;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: hard-iron removal and squares
      ax1_r  <= accel_x;
      ay1_r  <= accel_y;
      az1_r  <= accel_z;
      mx1_r  <= 17'(field_x) - 17'(off_x);
      my1_r  <= 17'(field_y) - 17'(off_y);
      mz1_r  <= 17'(field_z) - 17'(off_z);
      sqx1_r <= accel_x * accel_x;
      sqy1_r <= accel_y * accel_y;
      sqz1_r <= accel_z * accel_z;
      // stage 2: cross product terms
      ay2_r  <= ay1_r;
      az2_r  <= az1_r;
      myaz_r <= my1_r * az1_r;
      mzay_r <= mz1_r * ay1_r;
      mzax_r <= mz1_r * ax1_r;
      mxaz_r <= mx1_r * az1_r;
      mxay_r <= mx1_r * ay1_r;
      myax_r <= my1_r * ax1_r;
      asq2_r <= {1'b0, sqx1_r[30:0]} + {1'b0, sqy1_r[30:0]} + {1'b0, sqz1_r[30:0]};
      // stage 3: east vector
      ay3_r  <= ay2_r;
      az3_r  <= az2_r;
      ex3_r  <= 34'(myaz_r) - 34'(mzay_r);
      ey3_r  <= 34'(mzax_r) - 34'(mxaz_r);
      ez3_r  <= 34'(mxay_r) - 34'(myax_r);
      asq3_r <= asq2_r;
      // stage 4: north x terms; N is zero exactly when E is
      pn1_r    <= ay3_r * ez3_r;
      pn2_r    <= az3_r * ey3_r;
      ex4_r    <= ex3_r;
      degen4_r <= (ex3_r == '0) && (ey3_r == '0) && (ez3_r == '0);
      asq4_r   <= asq3_r;
      // stage 5
      side5_r.degen <= degen4_r;
      side5_r.ex    <= ex4_r;
      side5_r.nx    <= 51'(pn1_r) - 51'(pn2_r);
      asq5_r        <= asq4_r;
    end
  end

  assign out_vld  = vld_r[4];
  assign asq_out  = asq5_r;
  assign side_out = side5_r;

endmodule

`default_nettype wire

// ----- design/ttc_isqrt.sv -----
// Pipelined digit-by-digit square root of |a|^2 << 16, two bits per stage.
// Carries the side word along. Depends on ttc_pkg.
`default_nettype none

module ttc_isqrt import ttc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] asq_in,
  input  side_t       side_in,
  output logic        out_vld,
  output root_t       root_out,
  output side_t       side_out
);

  localparam int STAGES = SQRT_STEPS / STEPS_PER_STAGE;

  logic [REM_W-1:0] rem_r  [STAGES];
  root_t            root_r [STAGES];
  logic [RAD_W-1:0] rad_r  [STAGES];
  side_t            side_r [STAGES];
  logic             vld_r  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stg
    logic [REM_W-1:0] rem_in, rem_nxt;
    root_t            root_in, root_nxt;
    logic [RAD_W-1:0] rad_in, rad_nxt;
    side_t            side_in_s;
    logic             vld_in;

    if (s == 0) begin : g_first
      assign rem_in    = '0;
      assign root_in   = '0;
      assign rad_in    = {asq_in, 16'd0};
      assign side_in_s = side_in;
      assign vld_in    = in_vld;
    end else begin : g_next
      assign rem_in    = rem_r[s-1];
      assign root_in   = root_r[s-1];
      assign rad_in    = rad_r[s-1];
      assign side_in_s = side_r[s-1];
      assign vld_in    = vld_r[s-1];
    end

    // two restoring root steps
    always_comb begin
      logic [REM_W-1:0] cand;
      logic [REM_W-1:0] trial;
      rem_nxt  = rem_in;
      root_nxt = root_in;
      rad_nxt  = rad_in;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        cand    = {rem_nxt[REM_W-3:0], rad_nxt[RAD_W-1:RAD_W-2]};
        trial   = {1'b0, root_nxt, 2'b01};
        rad_nxt = {rad_nxt[RAD_W-3:0], 2'b00};
        if (cand >= trial) begin
          rem_nxt  = cand - trial;
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = cand;
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        rad_r[s]  <= rad_nxt;
        side_r[s] <= side_in_s;
      end
    end
  end

  assign out_vld  = vld_r[STAGES-1];
  assign root_out = root_r[STAGES-1];
  assign side_out = side_r[STAGES-1];

endmodule

`default_nettype wire

// ----- design/ttc_prescale.sv -----
// Forms y = E.x * r and x = N.x * 256, takes magnitudes and scales both
// below 2^30 by a common right shift. Four stages. Depends on ttc_pkg.
`default_nettype none

module ttc_prescale import ttc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  root_t             root_in,
  input  side_t             side_in,
  output logic              out_vld,
  output logic [PRE_W-1:0]  xp_out,
  output logic [PRE_W-1:0]  yp_out,
  output quad_t             quad_out
);

  logic [3:0] vld_r;

  prod_t             x1_r, y1_r;
  logic              dg1_r;
  logic [MAG_W-1:0]  xm2_r, ym2_r;
  quad_t             q2_r;
  logic [MAG_W-1:0]  xm3_r, ym3_r;
  logic [SHAMT_W-1:0] sh3_r;
  quad_t             q3_r;
  logic [PRE_W-1:0]  xp4_r, yp4_r;
  quad_t             q4_r;

  logic [SHAMT_W-1:0] lead;
  logic [SHAMT_W-1:0] sh_nxt;
  logic [MAG_W-1:0]   orv;
  logic [MAG_W-1:0]   xs_full, ys_full;

  // bit length of the larger magnitude
  assign orv = xm2_r | ym2_r;
  always_comb begin
    lead = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (orv[b]) lead = SHAMT_W'(b + 1);
    end
  end
  assign sh_nxt = (lead > SHAMT_W'(PRE_W)) ? lead - SHAMT_W'(PRE_W) : '0;

  assign xs_full = xm3_r >> sh3_r;
  assign ys_full = ym3_r >> sh3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: scaled components
      y1_r  <= side_in.ex * $signed({1'b0, root_in});
      x1_r  <= $signed({side_in.nx, 8'd0});
      dg1_r <= side_in.degen;
      // stage 2: magnitudes and signs
      xm2_r      <= x1_r[PROD_W-1] ? MAG_W'(-x1_r) : MAG_W'(x1_r);
      ym2_r      <= y1_r[PROD_W-1] ? MAG_W'(-y1_r) : MAG_W'(y1_r);
      q2_r.xneg  <= x1_r[PROD_W-1];
      q2_r.yneg  <= y1_r[PROD_W-1];
      q2_r.degen <= dg1_r;
      // stage 3: shift amount
      xm3_r <= xm2_r;
      ym3_r <= ym2_r;
      sh3_r <= sh_nxt;
      q3_r  <= q2_r;
      // stage 4: common shift
      xp4_r <= xs_full[PRE_W-1:0];
      yp4_r <= ys_full[PRE_W-1:0];
      q4_r  <= q3_r;
    end
  end

  assign out_vld  = vld_r[3];
  assign xp_out   = xp4_r;
  assign yp_out   = yp4_r;
  assign quad_out = q4_r;

endmodule

`default_nettype wire

// ----- design/ttc_cordic.sv -----
// CORDIC vectoring over 24 steps, two per stage, angle in 2^-20 degree.
// Carries the quadrant flags along. Depends on ttc_pkg.
`default_nettype none

module ttc_cordic import ttc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [PRE_W-1:0] xp_in,
  input  logic [PRE_W-1:0] yp_in,
  input  quad_t            quad_in,
  output logic             out_vld,
  output ang_t             z_out,
  output quad_t            quad_out
);

  localparam int STAGES = CORDIC_STEPS / STEPS_PER_STAGE;

  crd_t  x_r [STAGES];
  crd_t  y_r [STAGES];
  ang_t  z_r [STAGES];
  quad_t q_r [STAGES];
  logic  vld_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stg
    crd_t  x_in, y_in, x_nxt, y_nxt;
    ang_t  z_in, z_nxt;
    quad_t q_in;
    logic  vld_in;

    if (s == 0) begin : g_first
      assign x_in   = $signed({{(CRD_W-PRE_W){1'b0}}, xp_in});
      assign y_in   = $signed({{(CRD_W-PRE_W){1'b0}}, yp_in});
      assign z_in   = '0;
      assign q_in   = quad_in;
      assign vld_in = in_vld;
    end else begin : g_next
      assign x_in   = x_r[s-1];
      assign y_in   = y_r[s-1];
      assign z_in   = z_r[s-1];
      assign q_in   = q_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    // rotate toward the x axis
    always_comb begin
      crd_t dx;
      crd_t dy;
      x_nxt = x_in;
      y_nxt = y_in;
      z_nxt = z_in;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        dx = y_nxt >>> (s * STEPS_PER_STAGE + k);
        dy = x_nxt >>> (s * STEPS_PER_STAGE + k);
        if (!y_nxt[CRD_W-1] && (y_nxt != '0)) begin
          x_nxt = x_nxt + dx;
          y_nxt = y_nxt - dy;
          z_nxt = z_nxt + ATAN_TAB[s * STEPS_PER_STAGE + k];
        end else begin
          x_nxt = x_nxt - dx;
          y_nxt = y_nxt + dy;
          z_nxt = z_nxt - ATAN_TAB[s * STEPS_PER_STAGE + k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s] <= x_nxt;
        y_r[s] <= y_nxt;
        z_r[s] <= z_nxt;
        q_r[s] <= q_in;
      end
    end
  end

  assign out_vld  = vld_r[STAGES-1];
  assign z_out    = z_r[STAGES-1];
  assign quad_out = q_r[STAGES-1];

endmodule

`default_nettype wire
